// ===== rtl/tps_pkg.sv =====
// Shared constants, types and the sequencer microprogram for the
// two-pulse/saw sound generator. No dependencies.
package tps_pkg;

    localparam longint unsigned SOURCE_CLOCK_HZ = 64'd2048000;

    localparam int SR_W     = 18;
    localparam int PER_W    = 12;
    localparam int PROD_W   = SR_W + PER_W;
    localparam int DEN_W    = PROD_W + 4;          // k is at most 16
    localparam int DIV_W    = DEN_W + 1;           // divisor is 2*den
    // dividend 2*num + den, num = clock << 16
    localparam longint unsigned NUM2 = SOURCE_CLOCK_HZ << 17;
    localparam int DVD_W    = $clog2(NUM2 + (64'd1 << DEN_W));
    localparam int CNT_W    = $clog2(DVD_W);
    localparam int INC_W    = 16;
    localparam int PH_W     = 16;
    localparam int SAMPLE_W = 15;
    localparam int SUM_W    = 6;
    localparam int NCH      = 3;
    localparam int STEP_W   = 4;

    localparam logic [SR_W-1:0] SR_RESET = 18'd48000;

    localparam logic [1:0] CH_P0  = 2'd0;
    localparam logic [1:0] CH_P1  = 2'd1;
    localparam logic [1:0] CH_SAW = 2'd2;

    localparam logic [1:0] BYTE_CTL = 2'd0;
    localparam logic [1:0] BYTE_PLO = 2'd1;
    localparam logic [1:0] BYTE_PHI = 2'd2;

    // slot coordinates that hold no register
    localparam logic [1:0] CH_NONE   = 2'd3;
    localparam logic [1:0] BYTE_NONE = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE = 4'd0;
    localparam t_step ST_MUL0 = 4'd1;
    localparam t_step ST_LDD0 = 4'd2;
    localparam t_step ST_DIV0 = 4'd3;
    localparam t_step ST_STI0 = 4'd4;
    localparam t_step ST_MUL1 = 4'd5;
    localparam t_step ST_LDD1 = 4'd6;
    localparam t_step ST_DIV1 = 4'd7;
    localparam t_step ST_STI1 = 4'd8;
    localparam t_step ST_MUL2 = 4'd9;
    localparam t_step ST_LDD2 = 4'd10;
    localparam t_step ST_DIV2 = 4'd11;
    localparam t_step ST_STI2 = 4'd12;
    localparam t_step ST_EMIT = 4'd13;
    localparam t_step ST_BACK = 4'd14;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_TICK,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic       in_rdy;
        logic       ld_mul;
        logic       div_load;
        logic       div_step;
        logic       st_inc;
        logic       emit;
        logic [1:0] ch;
        t_cond      cond;
        t_step      target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
        logic saw;
    } t_div_ctl;

    function automatic t_uword mk(logic rdy, logic mul, logic ld, logic stp, logic sti,
                                  logic emt, logic [1:0] ch, t_cond cnd, t_step tgt);
        t_uword w;
        w.in_rdy   = rdy;
        w.ld_mul   = mul;
        w.div_load = ld;
        w.div_step = stp;
        w.st_inc   = sti;
        w.emit     = emt;
        w.ch       = ch;
        w.cond     = cnd;
        w.target   = tgt;
        return w;
    endfunction

    // microprogram ROM
    function automatic t_uword ucode(t_step s);
        t_uword w;
        case (s)
            ST_IDLE: w = mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CH_P0,  C_NO_TICK,  ST_IDLE);
            ST_MUL0: w = mk(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, CH_P0,  C_NEXT,     ST_IDLE);
            ST_LDD0: w = mk(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, CH_P0,  C_NEXT,     ST_IDLE);
            ST_DIV0: w = mk(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CH_P0,  C_DIV_MORE, ST_DIV0);
            ST_STI0: w = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, CH_P0,  C_NEXT,     ST_IDLE);
            ST_MUL1: w = mk(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, CH_P1,  C_NEXT,     ST_IDLE);
            ST_LDD1: w = mk(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, CH_P1,  C_NEXT,     ST_IDLE);
            ST_DIV1: w = mk(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CH_P1,  C_DIV_MORE, ST_DIV1);
            ST_STI1: w = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, CH_P1,  C_NEXT,     ST_IDLE);
            ST_MUL2: w = mk(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, CH_SAW, C_NEXT,     ST_IDLE);
            ST_LDD2: w = mk(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, CH_SAW, C_NEXT,     ST_IDLE);
            ST_DIV2: w = mk(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, CH_SAW, C_DIV_MORE, ST_DIV2);
            ST_STI2: w = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, CH_SAW, C_NEXT,     ST_IDLE);
            ST_EMIT: w = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, CH_P0,  C_OUT_BUSY, ST_EMIT);
            ST_BACK: w = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CH_P0,  C_ALWAYS,   ST_IDLE);
            default: w = mk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, CH_P0,  C_ALWAYS,   ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tps_if.sv =====
// Valid/ready channel interfaces: request item, sample result, config write.
// Depends on tps_pkg for widths.
interface tps_item_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [3:0] reg_index;
    logic [7:0] reg_data;
    modport source (output valid, output operation, output reg_index, output reg_data,
                    input ready);
    modport sink   (input valid, input operation, input reg_index, input reg_data,
                    output ready);
endinterface

interface tps_sample_if;
    logic                          valid;
    logic                          ready;
    logic [tps_pkg::SAMPLE_W-1:0]  sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tps_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [tps_pkg::SR_W-1:0]  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tps_div.sv =====
// Restoring divider, one quotient bit per cycle while stepped: round(2*num+den / 2*den).
// Depends on tps_pkg.
module tps_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tps_pkg::t_div_ctl           i_ctl,
    input  logic [tps_pkg::PROD_W-1:0]  i_prod,
    output logic                        o_more,
    output logic [tps_pkg::INC_W-1:0]   o_quot
);

    logic [tps_pkg::DEN_W-1:0]   den16, den2, den;
    logic [tps_pkg::DVD_W-1:0]   r_dvd;
    logic [tps_pkg::DIV_W-1:0]   r_dsr, r_rem;
    logic [tps_pkg::INC_W-1:0]   r_quot;
    logic [tps_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_zero;
    logic [tps_pkg::DIV_W:0]     trial;
    logic                        ge;

    // k*prod with k = 16, or 14 for the saw
    assign den16 = {i_prod, 4'b0000};
    assign den2  = {3'b000, i_prod, 1'b0};
    assign den   = i_ctl.saw ? (den16 - den2) : den16;

    assign trial = {r_rem, r_dvd[tps_pkg::DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= tps_pkg::CNT_W'(tps_pkg::DVD_W - 1);
        end else if (i_ctl.step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd  <= tps_pkg::DVD_W'(tps_pkg::NUM2) + tps_pkg::DVD_W'(den);
            r_dsr  <= {den, 1'b0};
            r_rem  <= '0;
            r_quot <= '0;
            r_zero <= den == '0;
        end else if (i_ctl.step) begin
            r_rem  <= ge ? tps_pkg::DIV_W'(trial - {1'b0, r_dsr})
                         : trial[tps_pkg::DIV_W-1:0];
            r_dvd  <= {r_dvd[tps_pkg::DVD_W-2:0], 1'b0};
            r_quot <= {r_quot[tps_pkg::INC_W-2:0], ge};
        end
    end

    assign o_more = r_cnt != '0;
    assign o_quot = r_zero ? '0 : r_quot;

endmodule

// ===== rtl/two_pulse_saw_sound_generator.sv =====
// Two pulse channels and one sawtooth on 16-bit phase accumulators.
// Write request: taken while idle, no result. Tick request: for each channel a
// multiply, a 39-step division on one shared divider and an increment store; then
// the sample is registered once the output is free; no request is taken meanwhile.
// Reset: registers and phases cleared, sample rate 48000; synchronous, low.
module two_pulse_saw_sound_generator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tps_item_if.sink      i_in,
    tps_cfg_if.sink       i_cfg,
    tps_sample_if.source  o_out
);

    // ---------------- sequencer -----------------
    tps_pkg::t_step   r_step, n_step;
    tps_pkg::t_uword  uw;
    logic             taken;
    logic             in_acc, tick, wr;
    logic             out_busy, emit_fire;
    logic             div_more;
    logic [tps_pkg::INC_W-1:0] div_quot;
    tps_pkg::t_div_ctl div_ctl;

    // ---------------- state ---------------------
    logic [tps_pkg::SR_W-1:0]   r_sr;
    logic [7:0]                 r_ctl [tps_pkg::NCH];   // byte 0 per channel
    logic [7:0]                 r_plo [tps_pkg::NCH];   // period low
    logic [7:0]                 r_phi [tps_pkg::NCH];   // enable, period high
    logic [tps_pkg::PH_W-1:0]   r_phase [tps_pkg::NCH];
    logic [tps_pkg::INC_W-1:0]  r_inc [tps_pkg::NCH];
    logic [tps_pkg::PROD_W-1:0] r_prod;
    logic                       r_out_valid;
    logic [tps_pkg::SAMPLE_W-1:0] r_out_sample;

    logic [tps_pkg::PER_W-1:0]  period;
    logic [1:0]                 wr_ch, wr_byte;

    // sample path
    logic [3:0]  s0, s1;
    logic [4:0]  s2;
    logic [18:0] saw_mul;
    logic [8:0]  saw_prod;
    logic [tps_pkg::SUM_W-1:0] sum;
    logic [tps_pkg::SUM_W+14:0] scaled;
    logic [tps_pkg::SAMPLE_W-1:0] mix;

    assign uw       = tps_pkg::ucode(r_step);
    assign i_in.ready = uw.in_rdy;
    assign in_acc   = i_in.valid && i_in.ready;
    assign tick     = in_acc && (i_in.operation == tps_pkg::OP_TICK);
    assign wr       = in_acc && (i_in.operation == tps_pkg::OP_WRITE);
    // output stage holds a sample nobody has taken yet
    assign out_busy = r_out_valid && !o_out.ready;
    assign emit_fire = uw.emit && !out_busy;

    always_comb begin
        case (uw.cond)
            tps_pkg::C_NEXT:     taken = 1'b0;
            tps_pkg::C_ALWAYS:   taken = 1'b1;
            tps_pkg::C_NO_TICK:  taken = !tick;
            tps_pkg::C_DIV_MORE: taken = div_more;
            tps_pkg::C_OUT_BUSY: taken = out_busy;
            default:             taken = 1'b1;
        endcase
        n_step = taken ? uw.target : tps_pkg::t_step'(r_step + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tps_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // ---------------- config --------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr <= tps_pkg::SR_RESET;
        end else if (i_cfg.valid) begin
            r_sr <= i_cfg.data;
        end
    end

    // ---------------- register writes -----------
    // slot = channel*4 + byte; byte 3 and channel 3 are holes
    assign wr_ch   = i_in.reg_index[3:2];
    assign wr_byte = i_in.reg_index[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < tps_pkg::NCH; c++) begin
                r_ctl[c] <= '0;
                r_plo[c] <= '0;
                r_phi[c] <= '0;
            end
        end else if (wr && wr_ch != tps_pkg::CH_NONE) begin
            case (wr_byte)
                tps_pkg::BYTE_CTL: r_ctl[wr_ch] <= i_in.reg_data;
                tps_pkg::BYTE_PLO: r_plo[wr_ch] <= i_in.reg_data;
                tps_pkg::BYTE_PHI: r_phi[wr_ch] <= i_in.reg_data;
                default: ;
            endcase
        end
    end

    // ---------------- increment datapath --------
    always_comb begin
        case (uw.ch)
            tps_pkg::CH_P0:  period = {r_phi[0][3:0], r_plo[0]};
            tps_pkg::CH_P1:  period = {r_phi[1][3:0], r_plo[1]};
            tps_pkg::CH_SAW: period = {r_phi[2][3:0], r_plo[2]};
            default:         period = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (uw.ld_mul) begin
            r_prod <= {{tps_pkg::PER_W{1'b0}}, r_sr} * {{tps_pkg::SR_W{1'b0}}, period};
        end
        if (uw.st_inc) begin
            r_inc[uw.ch] <= div_quot;
        end
    end

    assign div_ctl.load = uw.div_load;
    assign div_ctl.step = uw.div_step;
    assign div_ctl.saw  = uw.ch == tps_pkg::CH_SAW;

    tps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_prod  (r_prod),
        .o_more  (div_more),
        .o_quot  (div_quot)
    );

    // ---------------- mixer ---------------------
    // pulse high when phase >= 0x1000*(duty+1), i.e. top nibble above duty
    assign s0 = (r_phi[0][7] && r_phase[0][15:12] > {1'b0, r_ctl[0][6:4]})
                ? r_ctl[0][3:0] : 4'd0;
    assign s1 = (r_phi[1][7] && r_phase[1][15:12] > {1'b0, r_ctl[1][6:4]})
                ? r_ctl[1][3:0] : 4'd0;
    // saw: step 0..6 from phase*7 >> 16, times rate, low byte >> 3
    assign saw_mul  = {3'b000, r_phase[2]} * 19'd7;
    assign saw_prod = {6'd0, saw_mul[18:16]} * {3'd0, r_ctl[2][5:0]};
    assign s2       = r_phi[2][7] ? saw_prod[7:3] : 5'd0;

    assign sum    = tps_pkg::SUM_W'({2'b00, s0} + {2'b00, s1} + {1'b0, s2});
    // sum*32767 = sum*2^15 - sum; at most 61 in, so never reaches the clamp
    assign scaled = {sum, 15'd0} - {15'd0, sum};
    assign mix    = (scaled[tps_pkg::SUM_W+14:6] > tps_pkg::SUM_W'(0) + 15'h7FFF)
                    ? 15'h7FFF : scaled[tps_pkg::SAMPLE_W+5:6];

    // ---------------- phases and output stage ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < tps_pkg::NCH; c++) begin
                r_phase[c] <= '0;
            end
        end else if (emit_fire) begin
            for (int c = 0; c < tps_pkg::NCH; c++) begin
                r_phase[c] <= r_phase[c] + r_inc[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_sample <= mix;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_out_sample;

endmodule
